FILE: hdl/fence_gated_slot_pool_defines.svh
// Assertion macros shared by the slot pool modules.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef FENCE_GATED_SLOT_POOL_DEFINES_SVH
`define FENCE_GATED_SLOT_POOL_DEFINES_SVH

// Check a property on every rising edge outside of reset.
`define FGSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define FGSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/fgsp_pkg.sv
// Shared types and constants of the fence-gated slot pool.
// No dependencies; imported by fgsp_rem and the top level.
package fgsp_pkg;

  localparam int MaxEntries = 64;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int FenceW     = 64;
  localparam int CtrW       = 32;
  localparam logic [CntW-1:0] InitEntriesRst = CntW'(4);

  typedef enum logic [1:0] {
    ActAcquire = 2'd0,
    ActRelease = 2'd1,
    ActClear   = 2'd2,
    ActStart   = 2'd3
  } fgsp_action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StAcqFail  = 2'd1,
    StBadIndex = 2'd2
  } fgsp_status_e;

  typedef struct packed {
    fgsp_action_e        action;
    logic [FenceW-1:0]   fence_value;
    logic [IdxW-1:0]     slot_in;
  } fgsp_req_t;

  typedef struct packed {
    fgsp_status_e        status;
    logic [IdxW-1:0]     slot_out;
    logic                grew;
    logic [CntW-1:0]     total_count;
    logic [CntW-1:0]     busy_count;
  } fgsp_rsp_t;

endpackage

FILE: hdl/fgsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fgsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write on enable, register the read word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/fgsp_rem.sv
// Bit-serial remainder unit: rotate counter modulo the pool size.
// Depends on fgsp_pkg and the assertion macro header.
`include "fence_gated_slot_pool_defines.svh"
module fgsp_rem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fgsp_pkg::CtrW-1:0] dividend_i,
  input  logic [fgsp_pkg::CntW-1:0] divisor_i,
  output logic                      done_o,
  output logic [fgsp_pkg::IdxW-1:0] rem_o
);
  import fgsp_pkg::*;

  localparam int StepW = $clog2(CtrW);

  logic             run_q;
  logic [StepW-1:0] step_q;
  logic [CtrW-1:0]  dvd_q;
  logic [CntW-1:0]  dvs_q;
  logic [CntW-1:0]  r_q;
  logic [CntW:0]    trial;
  logic [CntW-1:0]  r_d;

  // Shift in one dividend bit, subtract the divisor when it fits
  always_comb begin
    trial = {r_q, dvd_q[CtrW-1]};
    if (trial >= {1'b0, dvs_q}) begin
      r_d = CntW'(trial - {1'b0, dvs_q});
    end else begin
      r_d = CntW'(trial);
    end
  end

  // Sequence one bit per cycle, MSB first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      r_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= StepW'(CtrW - 1);
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        r_q    <= '0;
      end else if (run_q) begin
        r_q   <= r_d;
        dvd_q <= {dvd_q[CtrW-2:0], 1'b0};
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end else begin
          step_q <= step_q - StepW'(1);
        end
      end
    end
  end

  assign rem_o = r_q[IdxW-1:0];

  `FGSP_ASSERT(a_rem_below_divisor, done_o |-> (r_q < dvs_q), "remainder not below divisor")
  `FGSP_ASSERT(a_no_instant_done, start_i |=> !done_o, "remainder done right after start")
  `FGSP_ASSERT(a_done_pulse, done_o |=> !done_o, "remainder done held over two cycles")

endmodule

FILE: hdl/fence_gated_slot_pool.sv
// Top level of the fence-gated slot pool: command decode, slot scan sequencer,
// busy flags and fence store. Depends on fgsp_pkg, fgsp_ram, fgsp_rem and the macro header.
//
// Usage:
//   A command beat (req_i: action, fence_value, slot_in) is taken at a rising
//   edge with start high and busy low. Each command yields one result beat on
//   rsp_o, marked by done_o for exactly one cycle; the receiver must take it.
//   initial_entries is written through cfg_we_i/cfg_wdata_i while idle.
// Command flow:
//   Release, clear and start answer in the cycle after the command; busy stays low,
//   so a new command may be issued every cycle.
//   Acquire on an empty pool answers in the cycle after the command. Otherwise each
//   pass runs the bit-serial remainder unit (rotate counter modulo pool size)
//   and then the scan, which reads one fence word per cycle from the fence RAM
//   and ends the pass on a hit or, once every slot was fetched, on a miss.
//   A failed pass doubles the pool (at most 64 slots) and repeats, until a hit
//   or a miss at 64 slots; busy is high throughout.
// Reset:
//   The pool is empty, the rotate counter is zero and initial_entries is 4.
//   Fence words are tracked by per-slot valid bits, so there is no clearing pass.
`include "fence_gated_slot_pool_defines.svh"
module fence_gated_slot_pool (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  fgsp_pkg::fgsp_req_t         req_i,
  output logic                        done_o,
  output fgsp_pkg::fgsp_rsp_t         rsp_o,
  input  logic                        cfg_we_i,
  input  logic [fgsp_pkg::CntW-1:0]   cfg_wdata_i
);
  import fgsp_pkg::*;

  typedef enum logic [1:0] {
    SIdle,
    SRem,
    SScan
  } state_e;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxEntries);

  state_e                state_q;
  logic [CntW-1:0]       init_q;
  logic [CntW-1:0]       active_q;
  logic [CtrW-1:0]       ctr_q;
  logic [MaxEntries-1:0] busy_flags_q;
  logic [MaxEntries-1:0] fvalid_q;
  logic [CntW-1:0]       busy_cnt_q;
  logic [CntW-1:0]       size_q;
  logic [FenceW-1:0]     fence_q;
  logic [IdxW-1:0]       idx_q;
  logic [CntW-1:0]       issue_q;
  logic                  pend_q;
  logic [IdxW-1:0]       pend_idx_q;
  logic                  grew_q;
  logic                  done_q;
  fgsp_rsp_t             rsp_q;

  logic                  accept;
  logic                  rel_ok;
  logic                  ram_we;
  logic [FenceW-1:0]     ram_rdata;
  logic [FenceW-1:0]     cmp_fence;
  logic                  hit;
  logic                  issuing;
  logic                  exhausted;
  logic [CntW:0]         dbl;
  logic [CntW-1:0]       grow_size;
  logic [CntW-1:0]       start_tgt;
  logic                  rem_start;
  logic [CntW-1:0]       rem_dvs;
  logic                  rem_done;
  logic [IdxW-1:0]       rem_val;
  logic [MaxEntries-1:0] live_mask;

  // Mark slots lo..hi-1
  function automatic logic [MaxEntries-1:0] span_mask(logic [CntW-1:0] lo,
                                                      logic [CntW-1:0] hi);
    logic [MaxEntries-1:0] m;
    m = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      m[i] = (CntW'(i) >= lo) && (CntW'(i) < hi);
    end
    return m;
  endfunction

  assign busy   = (state_q != SIdle);
  assign accept = start && !busy;
  assign rel_ok = ({1'b0, req_i.slot_in} < active_q);
  assign ram_we = accept && (req_i.action == ActRelease) && rel_ok;

  // Compare the fetched fence of the pending slot
  assign cmp_fence = fvalid_q[pend_idx_q] ? ram_rdata : '0;
  assign hit       = pend_q && !busy_flags_q[pend_idx_q] && (cmp_fence <= fence_q);
  assign issuing   = (issue_q < size_q);
  assign exhausted = !hit && !pend_q && !issuing;

  // Double the pool size, capped
  assign dbl       = {size_q, 1'b0};
  assign grow_size = (dbl > {1'b0, MaxCnt}) ? MaxCnt : CntW'(dbl);
  assign start_tgt = (init_q > MaxCnt) ? MaxCnt : init_q;

  // Launch a remainder pass on acquire into a non-empty pool or on a retry after growth
  always_comb begin
    rem_start = 1'b0;
    rem_dvs   = active_q;
    if (accept && (req_i.action == ActAcquire) && (active_q != '0)) begin
      rem_start = 1'b1;
    end else if ((state_q == SScan) && exhausted && (size_q < MaxCnt)) begin
      rem_start = 1'b1;
      rem_dvs   = grow_size;
    end
  end

  assign live_mask = span_mask('0, active_q);

  fgsp_ram #(
    .Width (FenceW),
    .Depth (MaxEntries)
  ) u_fence_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.slot_in),
    .wdata_i (req_i.fence_value),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  fgsp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (ctr_q),
    .divisor_i  (rem_dvs),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // Hold state, pool contents and the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      init_q       <= InitEntriesRst;
      active_q     <= '0;
      ctr_q        <= '0;
      busy_flags_q <= '0;
      fvalid_q     <= '0;
      busy_cnt_q   <= '0;
      size_q       <= '0;
      fence_q      <= '0;
      idx_q        <= '0;
      issue_q      <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      grew_q       <= 1'b0;
      done_q       <= 1'b0;
      rsp_q        <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        init_q <= cfg_wdata_i;
      end
      if (rem_start) begin
        ctr_q <= ctr_q + CtrW'(1);
      end
      unique case (state_q)
        SIdle: begin
          if (accept) begin
            unique case (req_i.action)
              ActAcquire: begin
                if (active_q == '0) begin
                  done_q <= 1'b1;
                  rsp_q  <= '{StAcqFail, '0, 1'b0, active_q, busy_cnt_q};
                end else begin
                  fence_q <= req_i.fence_value;
                  size_q  <= active_q;
                  grew_q  <= 1'b0;
                  state_q <= SRem;
                end
              end
              ActRelease: begin
                done_q <= 1'b1;
                if (!rel_ok) begin
                  rsp_q <= '{StBadIndex, '0, 1'b0, active_q, busy_cnt_q};
                end else begin
                  fvalid_q[req_i.slot_in]     <= 1'b1;
                  busy_flags_q[req_i.slot_in] <= 1'b0;
                  if (busy_flags_q[req_i.slot_in]) begin
                    busy_cnt_q <= busy_cnt_q - CntW'(1);
                    rsp_q <= '{StOk, '0, 1'b0, active_q, busy_cnt_q - CntW'(1)};
                  end else begin
                    rsp_q <= '{StOk, '0, 1'b0, active_q, busy_cnt_q};
                  end
                end
              end
              ActClear: begin
                done_q       <= 1'b1;
                active_q     <= '0;
                busy_flags_q <= '0;
                busy_cnt_q   <= '0;
                rsp_q        <= '{StOk, '0, 1'b0, '0, '0};
              end
              ActStart: begin
                done_q <= 1'b1;
                if (start_tgt > active_q) begin
                  fvalid_q <= fvalid_q & ~span_mask(active_q, start_tgt);
                  active_q <= start_tgt;
                  rsp_q    <= '{StOk, '0, 1'b0, start_tgt, busy_cnt_q};
                end else begin
                  rsp_q    <= '{StOk, '0, 1'b0, active_q, busy_cnt_q};
                end
              end
              default: ;
            endcase
          end
        end
        SRem: begin
          if (rem_done) begin
            idx_q   <= rem_val;
            issue_q <= '0;
            pend_q  <= 1'b0;
            state_q <= SScan;
          end
        end
        SScan: begin
          if (hit) begin
            // Grant the first eligible slot
            busy_flags_q[pend_idx_q] <= 1'b1;
            busy_cnt_q <= busy_cnt_q + CntW'(1);
            done_q     <= 1'b1;
            rsp_q      <= '{StOk, pend_idx_q, grew_q, active_q, busy_cnt_q + CntW'(1)};
            state_q    <= SIdle;
          end else if (exhausted) begin
            if (size_q >= MaxCnt) begin
              done_q  <= 1'b1;
              rsp_q   <= '{StAcqFail, '0, grew_q, active_q, busy_cnt_q};
              state_q <= SIdle;
            end else begin
              // Grow the pool with fresh slots and retry
              fvalid_q <= fvalid_q & ~span_mask(size_q, grow_size);
              active_q <= grow_size;
              size_q   <= grow_size;
              grew_q   <= 1'b1;
              state_q  <= SRem;
            end
          end else begin
            // Advance the fetch pointer around the pool
            pend_q     <= issuing;
            pend_idx_q <= idx_q;
            if (issuing) begin
              issue_q <= issue_q + CntW'(1);
              if ({1'b0, idx_q} == size_q - CntW'(1)) begin
                idx_q <= '0;
              end else begin
                idx_q <= idx_q + IdxW'(1);
              end
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `FGSP_ASSERT(a_busy_count,
               $countones(busy_flags_q) == int'(busy_cnt_q),
               "busy count mismatch")
  `FGSP_ASSERT(a_busy_in_pool, (busy_flags_q & ~live_mask) == '0, "busy slot outside pool")
  `FGSP_ASSERT(a_fail_slot_zero,
               (done_o && (rsp_o.status != StOk)) |-> (rsp_o.slot_out == '0),
               "slot set on failed beat")
  `FGSP_ASSERT(a_scan_in_pool,
               (state_q == SScan) |-> ({1'b0, idx_q} < size_q),
               "scan pointer outside pool")
  `FGSP_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> !busy, "busy during reset")

endmodule

FILE: verif/fence_gated_slot_pool_tb.sv
// Self-checking testbench for fence_gated_slot_pool: directed, exhaustion and random traffic
// checked against a shadow pool kept in the bench. Depends on fgsp_pkg and the block's RTL.
module fence_gated_slot_pool_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fgsp_pkg::*;

  localparam int GapPct     = 27;
  localparam int TailCycles = 40;
  localparam int PhaseBeats = 115;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  fgsp_req_t       req_i;
  logic            done_o;
  fgsp_rsp_t       rsp_o;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;

  // Shadow copy of the pool
  bit              pool_busy  [MaxEntries];
  bit [FenceW-1:0] pool_fence [MaxEntries];
  int unsigned     pool_size;
  bit [CtrW-1:0]   rot_ctr;
  int unsigned     init_slots;

  fgsp_rsp_t       pending_rsps[$];
  int unsigned     mismatches;
  int unsigned     beats_checked;
  int unsigned     n_acq, n_grant, n_grew, n_rel, n_bad_rel, n_clear, n_start;
  bit              gaps_on;
  bit [FenceW-1:0] done_fence;

  fence_gated_slot_pool u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Extend the pool up to target slots, fresh slots free with fence zero
  function automatic void pool_grow(int unsigned target);
    if (target > MaxEntries) target = MaxEntries;
    for (int unsigned i = pool_size; i < target; i++) begin
      pool_busy[i]  = 1'b0;
      pool_fence[i] = '0;
    end
    if (target > pool_size) pool_size = target;
  endfunction

  // Apply one command to the shadow pool and return the result beat it yields
  function automatic fgsp_rsp_t pool_step(fgsp_req_t cmd);
    fgsp_rsp_t   rsp;
    int unsigned size, first, idx, pick, nbusy;
    bit          found, finished;
    rsp        = '0;
    rsp.status = StOk;
    found      = 1'b0;
    pick       = 0;
    case (cmd.action)
      ActAcquire: begin
        if (pool_size == 0) begin
          rsp.status = StAcqFail;
        end else begin
          finished = 1'b0;
          // scan from the rotating start; double the pool and rescan on a miss
          while (!finished) begin
            size    = pool_size;
            first   = rot_ctr % size;
            rot_ctr = rot_ctr + 1'b1;
            for (int unsigned k = 0; k < size && !found; k++) begin
              idx = (first + k) % size;
              if (!pool_busy[idx] && pool_fence[idx] <= cmd.fence_value) begin
                found = 1'b1;
                pick  = idx;
              end
            end
            if (found || size >= MaxEntries) begin
              finished = 1'b1;
            end else begin
              pool_grow(size * 2);
              rsp.grew = 1'b1;
            end
          end
          if (found) begin
            pool_busy[pick] = 1'b1;
            rsp.slot_out    = pick[IdxW-1:0];
          end else begin
            rsp.status = StAcqFail;
          end
        end
      end
      ActRelease: begin
        if (cmd.slot_in >= pool_size) begin
          rsp.status = StBadIndex;
        end else begin
          pool_fence[cmd.slot_in] = cmd.fence_value;
          pool_busy[cmd.slot_in]  = 1'b0;
        end
      end
      ActClear: begin
        pool_size = 0;
      end
      default: begin
        pool_grow(init_slots);
      end
    endcase
    nbusy = 0;
    for (int unsigned i = 0; i < pool_size; i++) nbusy += pool_busy[i];
    rsp.total_count = CntW'(pool_size);
    rsp.busy_count  = CntW'(nbusy);
    return rsp;
  endfunction

  // Choose a busy slot in the active pool, else any index
  function automatic logic [IdxW-1:0] pick_busy_slot();
    int unsigned first, idx;
    first = $urandom_range(MaxEntries - 1);
    for (int unsigned k = 0; k < MaxEntries; k++) begin
      idx = (first + k) % MaxEntries;
      if (idx < pool_size && pool_busy[idx]) return IdxW'(idx);
    end
    return IdxW'(first);
  endfunction

  // Send one command beat, with a random hold-off, and log the result it should yield
  task automatic send_cmd(input fgsp_action_e act, input logic [FenceW-1:0] fence,
                          input logic [IdxW-1:0] slot);
    fgsp_req_t cmd;
    fgsp_rsp_t rsp;
    cmd.action      = act;
    cmd.fence_value = fence;
    cmd.slot_in     = slot;
    while (gaps_on && $urandom_range(99) < GapPct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy);
    rsp = pool_step(cmd);
    pending_rsps.insert(pending_rsps.size(), rsp);
    case (act)
      ActAcquire: begin
        n_acq++;
        if (rsp.status == StOk) n_grant++;
        if (rsp.grew) n_grew++;
      end
      ActRelease: begin
        n_rel++;
        if (rsp.status == StBadIndex) n_bad_rel++;
      end
      ActClear: n_clear++;
      default:  n_start++;
    endcase
  endtask

  // Drop start and wait until every result beat is back and the block is idle
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rsps.size() != 0 || busy) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Write initial_entries while the block is idle
  task automatic write_config(input logic [CntW-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    init_slots = int'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_cases();
    // commands against an empty pool
    send_cmd(ActAcquire, '0, '0);
    send_cmd(ActRelease, '1, IdxW'(0));
    send_cmd(ActClear, '1, '1);
    // grow to the reset size, then a start that changes nothing
    send_cmd(ActStart, '0, '0);
    send_cmd(ActStart, '1, '1);
    repeat (4) send_cmd(ActAcquire, '0, '0);
    // full pool forces a doubling
    send_cmd(ActAcquire, '1, '0);
    send_cmd(ActRelease, '1, IdxW'(2));
    send_cmd(ActAcquire, 64'hFFFF_FFFF_FFFF_FFFE, '1);
    // release of a free slot, then indexes just past and far past the pool
    send_cmd(ActRelease, 64'hA5A5_A5A5_5A5A_5A5A, IdxW'(7));
    send_cmd(ActRelease, '0, IdxW'(8));
    send_cmd(ActRelease, '0, IdxW'(63));
    send_cmd(ActClear, '0, '0);
    send_cmd(ActAcquire, '1, '0);
    // oversized initial count clamps at the pool maximum
    write_config(7'h7F);
    send_cmd(ActStart, '0, '0);
    send_cmd(ActAcquire, '0, '0);
    send_cmd(ActClear, '0, '0);
    // single-slot pool doubles on each miss
    write_config(CntW'(1));
    send_cmd(ActStart, '0, '0);
    repeat (3) send_cmd(ActAcquire, '0, '0);
  endtask

  task automatic test_pool_exhaustion();
    write_config(CntW'(MaxEntries));
    send_cmd(ActClear, '0, '0);
    send_cmd(ActStart, '0, '0);
    repeat (MaxEntries) send_cmd(ActAcquire, {$urandom, $urandom}, '0);
    // every slot busy at the maximum size
    send_cmd(ActAcquire, '1, '0);
    // freed slots still guarded by fences newer than the completed value
    for (int k = 0; k < 8; k++) send_cmd(ActRelease, 64'd1000 + k, pick_busy_slot());
    send_cmd(ActAcquire, 64'd500, '0);
    send_cmd(ActAcquire, 64'd1003, '0);
    send_cmd(ActAcquire, 64'd999, '0);
    send_cmd(ActRelease, '1, pick_busy_slot());
    send_cmd(ActAcquire, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    send_cmd(ActAcquire, '1, '0);
    send_cmd(ActClear, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [CntW-1:0] phase_cfg [10];
    int unsigned     sel;
    logic [FenceW-1:0] fence;
    phase_cfg = '{7'd1, 7'd64, 7'd2, 7'd127, 7'd7, 7'd33, 7'd5, 7'd48, 7'd1, 7'd64};
    for (int ph = 0; ph < 10; ph++) begin
      write_config(phase_cfg[ph]);
      // keep one phase back to back with no hold-off
      gaps_on = (ph != 3);
      for (int n = 0; n < PhaseBeats; n++) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          fence = ($urandom_range(9) == 0) ? {$urandom, $urandom} : done_fence;
          send_cmd(ActAcquire, fence, IdxW'($urandom_range(MaxEntries - 1)));
          done_fence += $urandom_range(2);
        end else if (sel < 85) begin
          if ($urandom_range(9) < 8) begin
            send_cmd(ActRelease, done_fence + $urandom_range(6), pick_busy_slot());
          end else begin
            send_cmd(ActRelease, {$urandom, $urandom}, IdxW'($urandom_range(MaxEntries - 1)));
          end
        end else if (sel < 93) begin
          send_cmd(ActStart, {$urandom, $urandom}, IdxW'($urandom_range(MaxEntries - 1)));
        end else if (sel < 97) begin
          send_cmd(ActClear, {$urandom, $urandom}, IdxW'($urandom_range(MaxEntries - 1)));
        end else begin
          // completed value at an extreme
          send_cmd(ActAcquire, $urandom_range(1) ? '1 : '0, '0);
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Compare each result beat with the oldest expected one
  always @(posedge clk_i) begin : check_results
    fgsp_rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsps.size() == 0) begin
        $display("%0t: expected none, actual status=%0d slot=%0d grew=%0d total=%0d busy=%0d",
                 $time, rsp_o.status, rsp_o.slot_out, rsp_o.grew, rsp_o.total_count,
                 rsp_o.busy_count);
        mismatches++;
      end else begin
        want = pending_rsps.pop_front();
        beats_checked++;
        if (rsp_o.status !== want.status || rsp_o.slot_out !== want.slot_out ||
            rsp_o.grew !== want.grew || rsp_o.total_count !== want.total_count ||
            rsp_o.busy_count !== want.busy_count) begin
          $display("%0t: mismatch: expected status=%0d slot=%0d grew=%0d total=%0d busy=%0d",
                   $time, want.status, want.slot_out, want.grew, want.total_count,
                   want.busy_count);
          $display("%0t:           actual   status=%0d slot=%0d grew=%0d total=%0d busy=%0d",
                   $time, rsp_o.status, rsp_o.slot_out, rsp_o.grew, rsp_o.total_count,
                   rsp_o.busy_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    gaps_on     = 1'b1;
    done_fence  = '0;
    pool_size   = 0;
    rot_ctr     = '0;
    init_slots  = int'(InitEntriesRst);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_pool_exhaustion();
    test_random_traffic();

    drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d acquires (%0d granted, %0d grew), %0d releases (%0d bad index),",
             n_acq, n_grant, n_grew, n_rel, n_bad_rel);
    $display("%0d clears and %0d starts; %0d result beats checked, %0d mismatches",
             n_clear, n_start, beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #100_000_000;
    $display("Timeout with %0d result beats outstanding", pending_rsps.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
